### rtl/spm_pkg.sv
// Shared types, codes and constants for the SDU/PDU multiplexer.
// Used by spm_ctrl, spm_datapath and sdu_pdu_multiplexer_top.
package spm_pkg;

  // Field widths of the transfers and of the running totals.
  localparam int LEN_W   = 12;
  localparam int SIZE_W  = 16;
  localparam int CLASS_W = 8;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 5;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Default storage sizes.
  localparam int STORE_BYTES_DEF = 2048;
  localparam int MAX_ENTRIES_DEF = 16;

  // Register reset values.
  localparam logic [LEN_W-1:0] CAP_RESET      = 12'd2048;
  localparam logic [CNT_W-1:0] MAX_SDUS_RESET = 5'd16;

  // PDU header bytes, and the per-SDU header bytes.
  localparam int HDR_BYTES = 2;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PDU_CAPACITY = 2'd0,
    REG_MAX_SDUS     = 2'd1
  } reg_idx_e;

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_TOO_MANY = 3'd2,
    ST_BYTE_OUT = 3'd3,
    ST_END      = 3'd4,
    ST_CONTROL  = 3'd5,
    ST_IGNORED  = 3'd6
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transfer
    logic commit;  // update state and load the result register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } dp_status_t;

endpackage

### rtl/spm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/spm_ctrl.sv
// Controller state machine: sequences capture and execution of one transfer.
// Depends on spm_pkg.
module spm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  spm_pkg::dp_status_t    dp_stat,
  output spm_pkg::ctrl_t         ctrl
);

  spm_pkg::state_t state;
  spm_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command outputs.
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.commit = 1'b0;
    case (state)
      spm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          state_next = spm_pkg::S_EXEC;
        end
      end
      spm_pkg::S_EXEC: begin
        // The result waits until the output register can take it.
        if (dp_stat.out_free) begin
          ctrl.commit = 1'b1;
          state_next  = spm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/spm_datapath.sv
// Datapath: configuration registers, running totals, byte store and SDU
// tables, result register. Depends on spm_pkg and spm_ram.
module spm_datapath #(
  parameter int STORE_BYTES = spm_pkg::STORE_BYTES_DEF,
  parameter int MAX_ENTRIES = spm_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spm_pkg::ctrl_t                   ctrl,
  output spm_pkg::dp_status_t              dp_stat,
  input  logic [spm_pkg::CMD_W-1:0]        s_tuser,
  input  logic [spm_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [spm_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [spm_pkg::STAT_W-1:0]       m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  input  logic [spm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W = 17;  // wide enough for size + header + length
  localparam int LIM_W = 9;   // wide enough for either entry limit

  localparam logic [CMP_W-1:0] STORE_LIM = CMP_W'(STORE_BYTES);
  localparam logic [LIM_W-1:0] ENTRY_LIM = LIM_W'(MAX_ENTRIES);

  // Configuration registers.
  logic [spm_pkg::LEN_W-1:0] pdu_capacity;
  logic [spm_pkg::CNT_W-1:0] max_sdus;

  // Running state.
  logic [spm_pkg::CNT_W-1:0]  sdu_count, sdu_count_next;
  logic [spm_pkg::LEN_W-1:0]  data_total, data_total_next;
  logic [spm_pkg::SIZE_W-1:0] bytes_pending, bytes_pending_next;
  logic [spm_pkg::CNT_W-1:0]  read_index, read_index_next;
  logic [spm_pkg::LEN_W-1:0]  read_position, read_position_next;
  logic [spm_pkg::SIZE_W-1:0] read_within, read_within_next;

  // Captured input transfer.
  spm_pkg::cmd_e               cmd_q;
  logic [spm_pkg::SIZE_W-1:0]  size_q;
  logic [spm_pkg::CLASS_W-1:0] class_q;
  logic [spm_pkg::BYTE_W-1:0]  byte_q;

  // Result register.
  spm_pkg::status_e           out_status, res_status;
  logic [spm_pkg::BYTE_W-1:0] out_byte, res_byte;
  logic                       out_last, res_last;
  logic [spm_pkg::SIZE_W-1:0] out_len, res_len;
  logic [spm_pkg::LEN_W-1:0]  out_pdu, res_pdu;

  // Memory ports.
  logic                        store_we, table_we;
  logic [spm_pkg::BYTE_W-1:0]  store_rdata;
  logic [spm_pkg::SIZE_W-1:0]  size_rdata;
  logic [spm_pkg::CLASS_W-1:0] class_rdata;

  // Derived values.
  logic [CMP_W-1:0]           cap_eff;
  logic [LIM_W-1:0]           lim_eff;
  logic [CMP_W-1:0]           pdu_len_cur;
  logic [CMP_W-1:0]           begin_need;
  logic [spm_pkg::LEN_W-1:0]  fill_point;
  logic [CMP_W-1:0]           within_inc;

  // Configuration writes; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      pdu_capacity <= spm_pkg::CAP_RESET;
      max_sdus     <= spm_pkg::MAX_SDUS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == spm_pkg::REG_PDU_CAPACITY) begin
        pdu_capacity <= cfg_data;
      end else if (cfg_index == spm_pkg::REG_MAX_SDUS) begin
        max_sdus <= cfg_data[spm_pkg::CNT_W-1:0];
      end
    end
  end

  // Capture the input transfer.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= spm_pkg::cmd_e'(s_tuser);
      size_q  <= s_tdata[15:0];
      class_q <= s_tdata[23:16];
      byte_q  <= s_tdata[31:24];
    end
  end

  // Effective limits and current lengths.
  always_comb begin
    cap_eff = (CMP_W'(pdu_capacity) < STORE_LIM) ? CMP_W'(pdu_capacity) : STORE_LIM;
    lim_eff = (LIM_W'(max_sdus) < ENTRY_LIM) ? LIM_W'(max_sdus) : ENTRY_LIM;
    pdu_len_cur = CMP_W'(spm_pkg::HDR_BYTES) + (CMP_W'(sdu_count) << 1)
                + CMP_W'(data_total);
    begin_need  = CMP_W'(size_q) + CMP_W'(spm_pkg::HDR_BYTES) + pdu_len_cur;
    fill_point  = data_total - bytes_pending[spm_pkg::LEN_W-1:0];
    within_inc  = CMP_W'(read_within) + CMP_W'(1);
  end

  // Command execution: next state and result fields.
  always_comb begin
    sdu_count_next     = sdu_count;
    data_total_next    = data_total;
    bytes_pending_next = bytes_pending;
    read_index_next    = read_index;
    read_position_next = read_position;
    read_within_next   = read_within;
    res_status         = spm_pkg::ST_IGNORED;
    res_byte           = '0;
    res_last           = 1'b0;
    res_len            = '0;
    store_we           = 1'b0;
    table_we           = 1'b0;
    case (cmd_q)
      spm_pkg::CMD_BEGIN: begin
        if (bytes_pending == '0) begin
          if (begin_need > cap_eff) begin
            res_status = spm_pkg::ST_TOO_LONG;
          end else if (LIM_W'(sdu_count) >= lim_eff) begin
            res_status = spm_pkg::ST_TOO_MANY;
          end else begin
            table_we           = ctrl.commit;
            sdu_count_next     = sdu_count + spm_pkg::CNT_W'(1);
            data_total_next    = data_total + size_q[spm_pkg::LEN_W-1:0];
            bytes_pending_next = size_q;
            res_status         = spm_pkg::ST_ACCEPTED;
          end
        end
      end
      spm_pkg::CMD_BYTE: begin
        if (bytes_pending != '0) begin
          store_we           = ctrl.commit;
          bytes_pending_next = bytes_pending - spm_pkg::SIZE_W'(1);
          res_status         = spm_pkg::ST_ACCEPTED;
        end
      end
      spm_pkg::CMD_FETCH: begin
        if (read_index >= sdu_count) begin
          res_status = spm_pkg::ST_END;
        end else begin
          res_len = size_rdata;
          if (class_rdata == '0) begin
            // A control SDU answers the same on every fetch.
            res_status = spm_pkg::ST_CONTROL;
          end else if (size_rdata == '0) begin
            // An empty data SDU is consumed with no byte.
            res_last         = 1'b1;
            read_index_next  = read_index + spm_pkg::CNT_W'(1);
            read_within_next = '0;
          end else if (read_position < fill_point) begin
            res_status         = spm_pkg::ST_BYTE_OUT;
            res_byte           = store_rdata;
            read_position_next = read_position + spm_pkg::LEN_W'(1);
            read_within_next   = within_inc[spm_pkg::SIZE_W-1:0];
            if (within_inc >= CMP_W'(size_rdata)) begin
              res_last         = 1'b1;
              read_index_next  = read_index + spm_pkg::CNT_W'(1);
              read_within_next = '0;
            end
          end
        end
      end
      spm_pkg::CMD_CLEAR: begin
        sdu_count_next     = '0;
        data_total_next    = '0;
        bytes_pending_next = '0;
        read_index_next    = '0;
        read_position_next = '0;
        read_within_next   = '0;
        res_status         = spm_pkg::ST_ACCEPTED;
      end
      default: begin
        res_status = spm_pkg::ST_IGNORED;
      end
    endcase
    res_pdu = spm_pkg::LEN_W'(spm_pkg::LEN_W'(spm_pkg::HDR_BYTES)
            + (spm_pkg::LEN_W'(sdu_count_next) << 1) + data_total_next);
  end

  // State registers, updated once per executed command.
  always_ff @(posedge clk) begin
    if (rst) begin
      sdu_count     <= '0;
      data_total    <= '0;
      bytes_pending <= '0;
      read_index    <= '0;
      read_position <= '0;
      read_within   <= '0;
    end else if (ctrl.commit) begin
      sdu_count     <= sdu_count_next;
      data_total    <= data_total_next;
      bytes_pending <= bytes_pending_next;
      read_index    <= read_index_next;
      read_position <= read_position_next;
      read_within   <= read_within_next;
    end
  end

  // Result register with its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_status <= res_status;
      out_byte   <= res_byte;
      out_last   <= res_last;
      out_len    <= res_len;
      out_pdu    <= res_pdu;
    end
  end

  assign dp_stat.out_free = !m_tvalid || m_tready;

  assign m_tuser = out_status;
  assign m_tlast = out_last;
  assign m_tdata = {4'b0000, out_pdu, out_len, out_byte};

  // Byte store: written at the fill point, read at the read position.
  spm_ram #(
    .WIDTH (spm_pkg::BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(fill_point)),
    .wdata (byte_q),
    .raddr (AW'(read_position)),
    .rdata (store_rdata)
  );

  // SDU size table: written at the SDU count, read at the read index.
  spm_ram #(
    .WIDTH (spm_pkg::SIZE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_size_tab (
    .clk   (clk),
    .we    (table_we),
    .waddr (EW'(sdu_count)),
    .wdata (size_q),
    .raddr (EW'(read_index)),
    .rdata (size_rdata)
  );

  // SDU class table, addressed as the size table.
  spm_ram #(
    .WIDTH (spm_pkg::CLASS_W),
    .DEPTH (MAX_ENTRIES)
  ) u_class_tab (
    .clk   (clk),
    .we    (table_we),
    .waddr (EW'(sdu_count)),
    .wdata (class_q),
    .raddr (EW'(read_index)),
    .rdata (class_rdata)
  );

endmodule

### rtl/sdu_pdu_multiplexer_top.sv
// SDU/PDU multiplexer top level: packs SDUs into a PDU byte store and
// reads them back in order. Each input transfer is first captured, while the
// store and tables present the data at the current read position, and then
// executed, which loads the result register; a new transfer is taken only
// after the last one has executed, the memories having a registered read. A
// result that is not taken holds the next command in its execution state.
// Configuration (register 0 PDU capacity, register 1 SDU limit) is accepted
// in every cycle and must only be written while the block is idle. Depends
// on spm_pkg, spm_ctrl, spm_datapath and spm_ram.
module sdu_pdu_multiplexer_top #(
  parameter int STORE_BYTES = spm_pkg::STORE_BYTES_DEF,
  parameter int MAX_ENTRIES = spm_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [spm_pkg::S_TDATA_W-1:0]  s_tdata,  // sdu_size, data_class, data_byte
  input  logic [spm_pkg::CMD_W-1:0]      s_tuser,  // command
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [spm_pkg::M_TDATA_W-1:0]  m_tdata,  // byte_out, out_sdu_length, pdu_length, pad
  output logic [spm_pkg::STAT_W-1:0]     m_tuser,  // status
  output logic                           m_tlast,  // sdu_last
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data
);

  spm_pkg::ctrl_t      ctrl;
  spm_pkg::dp_status_t dp_stat;

  assign cfg_ready = 1'b1;

  // Controller.
  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .dp_stat  (dp_stat),
    .ctrl     (ctrl)
  );

  // Datapath.
  spm_datapath #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .dp_stat   (dp_stat),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for sdu_pdu_multiplexer_top: directed and random command streams,
// checked transfer by transfer against a behavioural model of the SDU/PDU store.
// Depends on spm_pkg and the RTL of the multiplexer.
`timescale 1ns / 1ps

module testbench;

  localparam int MODEL_STORE   = 2048;
  localparam int MODEL_ENTRIES = 16;
  localparam int RANDOM_ITEMS  = 600;
  localparam int LONG_HOLD     = 200;

  // One input item and one result item.
  typedef struct packed {
    spm_pkg::cmd_e cmd;
    logic [15:0]   size;
    logic [7:0]    cls;
    logic [7:0]    dbyte;
  } mux_item_t;

  typedef struct packed {
    spm_pkg::status_e status;
    logic [7:0]       byte_out;
    logic             sdu_last;
    logic [15:0]      sdu_len;
    logic [11:0]      pdu_len;
  } mux_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [spm_pkg::S_TDATA_W-1:0]  s_tdata = '0;
  logic [spm_pkg::CMD_W-1:0]      s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [spm_pkg::M_TDATA_W-1:0]  m_tdata;
  logic [spm_pkg::STAT_W-1:0]     m_tuser;
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus and expectation queues, and handshake flags seen at the last rising edge.
  mux_item_t   item_q[$];
  mux_result_t result_q[$];
  bit          s_took = 1'b0;
  bit          cfg_took = 1'b0;
  int          mismatches = 0;
  int          pushed = 0;

  // Idling controls shared by the initial block and the two drivers.
  int          idle_pct = 20;
  bit          calm = 1'b0;
  int          stall_asks = 0;
  int          stall_seen = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;

  // Model state and configuration.
  logic [7:0]  store_mem [MODEL_STORE];
  logic [15:0] entry_size [MODEL_ENTRIES];
  logic [7:0]  entry_class [MODEL_ENTRIES];
  logic [4:0]  n_sdus = '0;
  logic [11:0] fill_total = '0;
  logic [15:0] left_to_write = '0;
  logic [4:0]  rd_entry = '0;
  logic [11:0] rd_addr = '0;
  logic [15:0] rd_offset = '0;
  logic [11:0] cap_reg = spm_pkg::CAP_RESET;
  logic [4:0]  sdu_limit = spm_pkg::MAX_SDUS_RESET;

  sdu_pdu_multiplexer_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Works out the result of one command and advances the model state.
  function automatic mux_result_t mux_predict(spm_pkg::cmd_e cmd, logic [15:0] size,
                                              logic [7:0] cls, logic [7:0] dbyte);
    mux_result_t r;
    int unsigned cap, lim, cur_len, pos, sz;
    r = '{status: spm_pkg::ST_IGNORED, byte_out: '0, sdu_last: 1'b0, sdu_len: '0,
          pdu_len: '0};
    cap = (cap_reg < MODEL_STORE) ? cap_reg : MODEL_STORE;
    lim = (sdu_limit < MODEL_ENTRIES) ? sdu_limit : MODEL_ENTRIES;
    cur_len = spm_pkg::HDR_BYTES + 2 * n_sdus + fill_total;
    case (cmd)
      spm_pkg::CMD_BEGIN: begin
        if (left_to_write == 0) begin
          if (size + 2 + cur_len > cap) begin
            r.status = spm_pkg::ST_TOO_LONG;
          end else if (n_sdus >= lim) begin
            r.status = spm_pkg::ST_TOO_MANY;
          end else begin
            entry_size[n_sdus[3:0]]  = size;
            entry_class[n_sdus[3:0]] = cls;
            n_sdus        = n_sdus + 5'd1;
            fill_total    = fill_total + size[11:0];
            left_to_write = size;
            r.status      = spm_pkg::ST_ACCEPTED;
          end
        end
      end
      spm_pkg::CMD_BYTE: begin
        if (left_to_write != 0) begin
          pos = fill_total - left_to_write;
          if (pos < MODEL_STORE) store_mem[pos[10:0]] = dbyte;
          left_to_write = left_to_write - 16'd1;
          r.status = spm_pkg::ST_ACCEPTED;
        end
      end
      spm_pkg::CMD_FETCH: begin
        if (rd_entry >= n_sdus || rd_entry >= MODEL_ENTRIES) begin
          r.status = spm_pkg::ST_END;
        end else begin
          sz = entry_size[rd_entry[3:0]];
          r.sdu_len = 16'(sz);
          if (entry_class[rd_entry[3:0]] == 0) begin
            r.status = spm_pkg::ST_CONTROL;
          end else if (sz == 0) begin
            // An empty data SDU is consumed without a byte.
            r.sdu_last = 1'b1;
            rd_entry   = rd_entry + 5'd1;
            rd_offset  = '0;
          end else if (rd_addr < fill_total - left_to_write && rd_addr < MODEL_STORE) begin
            r.status   = spm_pkg::ST_BYTE_OUT;
            r.byte_out = store_mem[rd_addr[10:0]];
            rd_addr    = rd_addr + 12'd1;
            rd_offset  = rd_offset + 16'd1;
            if (rd_offset >= sz) begin
              r.sdu_last = 1'b1;
              rd_entry   = rd_entry + 5'd1;
              rd_offset  = '0;
            end
          end
        end
      end
      default: begin
        n_sdus        = '0;
        fill_total    = '0;
        left_to_write = '0;
        rd_entry      = '0;
        rd_addr       = '0;
        rd_offset     = '0;
        r.status      = spm_pkg::ST_ACCEPTED;
      end
    endcase
    r.pdu_len = 12'(spm_pkg::HDR_BYTES + 2 * n_sdus + fill_total);
    return r;
  endfunction

  // Rising edge: record handshakes, predict accepted commands, check results.
  always @(posedge clk) begin
    mux_result_t got, want;
    s_took   = !rst && s_tvalid && s_tready;
    cfg_took = !rst && cfg_valid && cfg_ready;
    if (cfg_took) begin
      case (spm_pkg::reg_idx_e'(cfg_index))
        spm_pkg::REG_PDU_CAPACITY: cap_reg = cfg_data;
        spm_pkg::REG_MAX_SDUS:     sdu_limit = cfg_data[4:0];
        default: ;
      endcase
    end
    if (s_took)
      result_q.push_back(mux_predict(spm_pkg::cmd_e'(s_tuser), s_tdata[15:0],
                                     s_tdata[23:16], s_tdata[31:24]));
    if (!rst && m_tvalid && m_tready) begin
      got = '{status: spm_pkg::status_e'(m_tuser), byte_out: m_tdata[7:0],
              sdu_last: m_tlast, sdu_len: m_tdata[23:8], pdu_len: m_tdata[35:24]};
      if (result_q.size() == 0) begin
        $display("%0t: expected nothing, got status %0d byte %h last %b len %0d pdu %0d",
                 $time, got.status, got.byte_out, got.sdu_last, got.sdu_len, got.pdu_len);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected status %0d byte %h last %b len %0d pdu %0d",
                   $time, want.status, want.byte_out, want.sdu_last, want.sdu_len,
                   want.pdu_len);
          $display("%0t: actual   status %0d byte %h last %b len %0d pdu %0d",
                   $time, got.status, got.byte_out, got.sdu_last, got.sdu_len,
                   got.pdu_len);
          mismatches++;
        end
      end
    end
  end

  // Command driver: offers queued items at the falling edge, with random gaps.
  always @(negedge clk) begin
    mux_item_t nxt;
    logic      offer;
    if (rst) begin
      offer = 1'b0;
    end else if (s_tvalid && !s_took) begin
      offer = 1'b1;
    end else if (tx_gap > 0) begin
      tx_gap--;
      offer = 1'b0;
    end else if (item_q.size() > 0) begin
      nxt = item_q.pop_front();
      s_tdata <= {nxt.dbyte, nxt.cls, nxt.size};
      s_tuser <= nxt.cmd;
      offer = 1'b1;
      if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        tx_gap = $urandom_range(1, 8);
    end else begin
      offer = 1'b0;
    end
    s_tvalid <= offer;
  end

  // Result receiver: random back-pressure bursts and one long hold-off on request.
  always @(negedge clk) begin
    logic ready_n;
    if (stall_asks != stall_seen) begin
      stall_seen = stall_asks;
      hold_left  = LONG_HOLD;
    end
    if (rst) begin
      ready_n = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ready_n = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      ready_n = 1'b0;
    end else begin
      ready_n = 1'b1;
      if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        rx_gap = $urandom_range(1, 8);
    end
    m_tready <= ready_n;
  end

  task automatic push_item(spm_pkg::cmd_e cmd, logic [15:0] size, logic [7:0] cls,
                           logic [7:0] dbyte);
    item_q.push_back('{cmd: cmd, size: size, cls: cls, dbyte: dbyte});
    pushed++;
  endtask

  // Pushes a command whose fields are all random.
  task automatic push_noise(spm_pkg::cmd_e cmd);
    push_item(cmd, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Waits until every queued item has been taken and every result has arrived.
  task automatic wait_idle();
    while (item_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(spm_pkg::reg_idx_e idx, logic [11:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // A run of well-formed SDUs with random content, mixed with fetches, noise and cut-short runs.
  task automatic gen_frame();
    int sz, cls, k, total;
    total = 0;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0:       sz = $urandom_range(0, 65535);
        1, 2:    sz = $urandom_range(9, 40);
        default: sz = $urandom_range(0, 8);
      endcase
      cls = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
      push_item(spm_pkg::CMD_BEGIN, sz[15:0], cls[7:0], 8'($urandom));
      k = (sz > 48) ? 0 : sz;
      if ($urandom_range(0, 19) == 0) k = $urandom_range(0, k);
      total += k + 1;
      repeat (k) begin
        if ($urandom_range(0, 3) == 0) push_noise(spm_pkg::CMD_FETCH);
        if ($urandom_range(0, 15) == 0)
          push_noise(spm_pkg::cmd_e'($urandom_range(0, 3)));
        push_noise(spm_pkg::CMD_BYTE);
      end
    end
    repeat (total + $urandom_range(0, 3)) push_noise(spm_pkg::CMD_FETCH);
    if ($urandom_range(0, 9) < 6) push_noise(spm_pkg::CMD_CLEAR);
  endtask

  // Picks a capacity and an SDU limit, extremes included.
  task automatic random_config();
    logic [11:0] cap;
    logic [4:0]  lim;
    case ($urandom_range(0, 9))
      0, 1, 2: cap = 12'd2048;
      3:       cap = 12'd4095;
      4:       cap = 12'($urandom_range(0, 1));
      5, 6:    cap = 12'($urandom_range(2, 40));
      default: cap = 12'($urandom_range(2, 4095));
    endcase
    case ($urandom_range(0, 7))
      0:       lim = 5'd0;
      1:       lim = 5'd1;
      2:       lim = 5'd31;
      3, 4:    lim = 5'd16;
      default: lim = 5'($urandom_range(0, 31));
    endcase
    write_reg(spm_pkg::REG_PDU_CAPACITY, cap);
    write_reg(spm_pkg::REG_MAX_SDUS, {7'($urandom_range(0, 127)), lim});
  endtask

  // Main sequence: reset, directed cases, random phases, then a calm finish.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: defaults, empty fetch, stray byte, pending begin, fetch at the fill
    // point, empty data SDU, control SDU, oversize begin, clear.
    idle_pct = 0;
    write_reg(spm_pkg::REG_PDU_CAPACITY, 12'd2048);
    write_reg(spm_pkg::REG_MAX_SDUS, 12'd16);
    push_item(spm_pkg::CMD_FETCH, 16'h0000, 8'h00, 8'h00);
    push_item(spm_pkg::CMD_BYTE,  16'hFFFF, 8'hFF, 8'hFF);
    push_item(spm_pkg::CMD_BEGIN, 16'd3,    8'hFF, 8'h00);
    push_item(spm_pkg::CMD_BEGIN, 16'd1,    8'h01, 8'h00);
    push_item(spm_pkg::CMD_FETCH, 16'h0000, 8'h00, 8'h00);
    push_item(spm_pkg::CMD_BYTE,  16'h0000, 8'h00, 8'h00);
    push_item(spm_pkg::CMD_BYTE,  16'h0000, 8'h00, 8'hFF);
    push_item(spm_pkg::CMD_BYTE,  16'h0000, 8'h00, 8'hA5);
    push_item(spm_pkg::CMD_BEGIN, 16'd0,    8'h01, 8'h00);
    push_item(spm_pkg::CMD_BEGIN, 16'd2,    8'h00, 8'h00);
    push_item(spm_pkg::CMD_BYTE,  16'h0000, 8'h00, 8'h5A);
    push_item(spm_pkg::CMD_BYTE,  16'h0000, 8'h00, 8'hC3);
    push_item(spm_pkg::CMD_BEGIN, 16'hFFFF, 8'h80, 8'h00);
    repeat (4) push_item(spm_pkg::CMD_FETCH, 16'hFFFF, 8'hFF, 8'hFF);
    repeat (2) push_item(spm_pkg::CMD_FETCH, 16'h0000, 8'h00, 8'h00);
    push_item(spm_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00);
    push_item(spm_pkg::CMD_FETCH, 16'h0000, 8'h00, 8'h00);
    wait_idle();

    // Capacity below the header: every begin is too long.
    write_reg(spm_pkg::REG_PDU_CAPACITY, 12'd0);
    write_reg(spm_pkg::REG_MAX_SDUS, 12'd31);
    push_item(spm_pkg::CMD_BEGIN, 16'd0, 8'h01, 8'h00);
    push_item(spm_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00);
    wait_idle();

    // Oversized capacity with room for one SDU only.
    write_reg(spm_pkg::REG_PDU_CAPACITY, 12'd4095);
    write_reg(spm_pkg::REG_MAX_SDUS, 12'd1);
    push_item(spm_pkg::CMD_BEGIN, 16'd0, 8'hFE, 8'h00);
    push_item(spm_pkg::CMD_BEGIN, 16'd0, 8'h01, 8'h00);
    push_item(spm_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00);
    wait_idle();

    // Size check against a tight capacity comes before the SDU limit.
    write_reg(spm_pkg::REG_PDU_CAPACITY, 12'd10);
    write_reg(spm_pkg::REG_MAX_SDUS, 12'd0);
    push_item(spm_pkg::CMD_BEGIN, 16'd7, 8'h01, 8'h00);
    push_item(spm_pkg::CMD_BEGIN, 16'd6, 8'h01, 8'h00);
    push_item(spm_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00);
    wait_idle();

    // Back-pressure: the receiver holds off while the sender keeps offering.
    pushed = 0;
    idle_pct = 0;
    write_reg(spm_pkg::REG_PDU_CAPACITY, 12'd2048);
    write_reg(spm_pkg::REG_MAX_SDUS, 12'd16);
    stall_asks++;
    repeat (3) gen_frame();
    wait_idle();

    // Random phases, each ending with a pause until all results are in.
    while (pushed < RANDOM_ITEMS) begin
      random_config();
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 50;
        default: idle_pct = 15;
      endcase
      repeat ($urandom_range(1, 4)) gen_frame();
      wait_idle();
    end

    // Final stretch with no idling on either side.
    calm = 1'b1;
    write_reg(spm_pkg::REG_PDU_CAPACITY, 12'd2048);
    write_reg(spm_pkg::REG_MAX_SDUS, 12'd16);
    repeat (3) gen_frame();
    wait_idle();
    repeat (10) @(posedge clk);

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/spm_pkg.sv
rtl/spm_ram.sv
rtl/spm_ctrl.sv
rtl/spm_datapath.sv
rtl/sdu_pdu_multiplexer_top.sv
sim/testbench.sv
